[src/assert_macros.svh]
// Assertion macros used by the checker file.
// Both macros sample on the rising clock edge and are disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every sampled edge.
`define CHK_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[src/cau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation and status codes shared by the pipeline modules.
// ----------------------------------------------------------------------------
package cau_pkg;

	// Operation codes carried by each item.
	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_MUL  = 2'd1,
		CMD_DIV  = 2'd2,
		CMD_CONJ = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIVZ = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

endpackage

[src/cau_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Two stages: partial products, then sum, sign and magnitude of each part
// together with the divisor norm |y|^2.
// ----------------------------------------------------------------------------
module cau_front #(
	parameter int DW = 16,
	parameter int F  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cau_pkg::cmd_t        cmd,
	input  logic signed [DW-1:0] x_re,
	input  logic signed [DW-1:0] x_im,
	input  logic signed [DW-1:0] y_re,
	input  logic signed [DW-1:0] y_im,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cau_pkg::cmd_t        out_cmd,
	output logic                 neg_re,
	output logic [2*DW-1:0]      mag_re,
	output logic                 neg_im,
	output logic [2*DW-1:0]      mag_im,
	output logic [2*DW-1:0]      den,
	output logic                 dzero
);

	localparam int MW = 2 * DW;
	localparam int SW = MW + 1;

	logic                 vld_s1, vld_s2;
	logic                 en1, en2;
	cau_pkg::cmd_t        cmd_s1;
	logic signed [DW-1:0] xr_s1, xi_s1, yr_s1, yi_s1;
	logic signed [MW-1:0] prr_s1, pii_s1, pri_s1, pir_s1, pyr_s1, pyi_s1;

	logic signed [SW-1:0] sre, sim;
	logic [SW-1:0]        are, aim;
	logic [MW-1:0]        mre, mim;
	logic [MW-1:0]        dsum;

	// A stage moves when it is empty or the next one moves.
	assign en2      = !vld_s2 || !out_stall;
	assign en1      = !vld_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = vld_s2;

	// Stage 1: operands and the six products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			cmd_s1 <= cmd;
			xr_s1  <= x_re;
			xi_s1  <= x_im;
			yr_s1  <= y_re;
			yi_s1  <= y_im;
			prr_s1 <= x_re * y_re;
			pii_s1 <= x_im * y_im;
			pri_s1 <= x_re * y_im;
			pir_s1 <= x_im * y_re;
			pyr_s1 <= y_re * y_re;
			pyi_s1 <= y_im * y_im;
		end
	end

	// Signed sums for each operation.
	always_comb begin
		case (cmd_s1)
			cau_pkg::CMD_ADD: begin
				sre = SW'(xr_s1) + SW'(yr_s1);
				sim = SW'(xi_s1) + SW'(yi_s1);
			end
			cau_pkg::CMD_MUL: begin
				sre = SW'(prr_s1) - SW'(pii_s1);
				sim = SW'(pri_s1) + SW'(pir_s1);
			end
			cau_pkg::CMD_DIV: begin
				sre = SW'(prr_s1) + SW'(pii_s1);
				sim = SW'(pir_s1) - SW'(pri_s1);
			end
			default: begin
				sre = SW'(xr_s1);
				sim = -SW'(xi_s1);
			end
		endcase
		are  = sre[SW-1] ? SW'(-sre) : SW'(sre);
		aim  = sim[SW-1] ? SW'(-sim) : SW'(sim);
		mre  = are[MW-1:0];
		mim  = aim[MW-1:0];
		dsum = MW'(unsigned'(pyr_s1)) + MW'(unsigned'(pyi_s1));
	end

	// Stage 2: sign, magnitude (rescaled for products) and divisor norm.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			out_cmd <= cmd_s1;
			neg_re  <= sre[SW-1];
			neg_im  <= sim[SW-1];
			mag_re  <= (cmd_s1 == cau_pkg::CMD_MUL) ? (mre >> F) : mre;
			mag_im  <= (cmd_s1 == cau_pkg::CMD_MUL) ? (mim >> F) : mim;
			den     <= dsum;
			dzero   <= (dsum == '0);
		end
	end

endmodule

[src/cau_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider
// Pipelined restoring divider for both parts: one overflow check stage, then
// one quotient bit per stage. Other operations ride along unchanged.
// ----------------------------------------------------------------------------
module cau_div #(
	parameter int DW = 16,
	parameter int F  = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  cau_pkg::cmd_t   cmd,
	input  logic            neg_re,
	input  logic [2*DW-1:0] mag_re,
	input  logic            neg_im,
	input  logic [2*DW-1:0] mag_im,
	input  logic [2*DW-1:0] den,
	input  logic            dzero,
	output logic            out_valid,
	input  logic            out_stall,
	output cau_pkg::cmd_t   out_cmd,
	output logic            out_neg_re,
	output logic [2*DW-1:0] out_mag_re,
	output logic            out_neg_im,
	output logic [2*DW-1:0] out_mag_im,
	output logic [DW:0]     q_re,
	output logic [DW:0]     q_im,
	output logic            ovf_re,
	output logic            ovf_im,
	output logic            out_dzero
);

	localparam int MW = 2 * DW;
	localparam int NW = MW + F;
	localparam int QB = DW + 1;
	localparam int HW = NW - QB;
	localparam int CW = (HW > MW) ? HW : MW;

	logic [QB:0] vld_s;
	logic [QB:0] en;

	cau_pkg::cmd_t cmd_s   [0:QB];
	logic          nre_s   [0:QB];
	logic          nim_s   [0:QB];
	logic [MW-1:0] mre_s   [0:QB];
	logic [MW-1:0] mim_s   [0:QB];
	logic [MW-1:0] den_s   [0:QB];
	logic          dz_s    [0:QB];
	logic          ovre_s  [0:QB];
	logic          ovim_s  [0:QB];
	logic [MW-1:0] rre_s   [0:QB];
	logic [MW-1:0] rim_s   [0:QB];
	logic [QB-1:0] lre_s   [0:QB];
	logic [QB-1:0] lim_s   [0:QB];
	logic [QB-1:0] qre_s   [0:QB];
	logic [QB-1:0] qim_s   [0:QB];

	logic [NW-1:0] nre, nim;
	logic [HW-1:0] hre, him;
	logic          ore, oim;

	// Backpressure chain, last stage first.
	always_comb begin
		en[QB] = !vld_s[QB] || !out_stall;
		for (int i = QB - 1; i >= 0; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	assign in_stall = !en[0];

	// Valid bits for all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int i = 1; i <= QB; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// Scaled numerators; a high part at or above the divisor means overflow.
	always_comb begin
		nre = NW'(mag_re) << F;
		nim = NW'(mag_im) << F;
		hre = nre[NW-1:QB];
		him = nim[NW-1:QB];
		ore = CW'(hre) >= CW'(den);
		oim = CW'(him) >= CW'(den);
	end

	// Stage 0: overflow check and initial partial remainder.
	always_ff @(posedge clk) begin
		if (en[0] && in_valid) begin
			cmd_s[0]  <= cmd;
			nre_s[0]  <= neg_re;
			nim_s[0]  <= neg_im;
			mre_s[0]  <= mag_re;
			mim_s[0]  <= mag_im;
			den_s[0]  <= den;
			dz_s[0]   <= dzero;
			ovre_s[0] <= ore;
			ovim_s[0] <= oim;
			rre_s[0]  <= ore ? '0 : MW'(hre);
			rim_s[0]  <= oim ? '0 : MW'(him);
			lre_s[0]  <= nre[QB-1:0];
			lim_s[0]  <= nim[QB-1:0];
			qre_s[0]  <= '0;
			qim_s[0]  <= '0;
		end
	end

	// One quotient bit per stage.
	for (genvar g = 1; g <= QB; g++) begin : g_bit
		logic [MW:0] tre, tim, dx;
		logic        gre, gim;

		always_comb begin
			dx  = {1'b0, den_s[g-1]};
			tre = {rre_s[g-1], lre_s[g-1][QB-1]};
			tim = {rim_s[g-1], lim_s[g-1][QB-1]};
			gre = tre >= dx;
			gim = tim >= dx;
		end

		always_ff @(posedge clk) begin
			if (en[g] && vld_s[g-1]) begin
				cmd_s[g]  <= cmd_s[g-1];
				nre_s[g]  <= nre_s[g-1];
				nim_s[g]  <= nim_s[g-1];
				mre_s[g]  <= mre_s[g-1];
				mim_s[g]  <= mim_s[g-1];
				den_s[g]  <= den_s[g-1];
				dz_s[g]   <= dz_s[g-1];
				ovre_s[g] <= ovre_s[g-1];
				ovim_s[g] <= ovim_s[g-1];
				rre_s[g]  <= gre ? MW'(tre - dx) : MW'(tre);
				rim_s[g]  <= gim ? MW'(tim - dx) : MW'(tim);
				lre_s[g]  <= lre_s[g-1] << 1;
				lim_s[g]  <= lim_s[g-1] << 1;
				qre_s[g]  <= {qre_s[g-1][QB-2:0], gre};
				qim_s[g]  <= {qim_s[g-1][QB-2:0], gim};
			end
		end
	end

	assign out_valid  = vld_s[QB];
	assign out_cmd    = cmd_s[QB];
	assign out_neg_re = nre_s[QB];
	assign out_neg_im = nim_s[QB];
	assign out_mag_re = mre_s[QB];
	assign out_mag_im = mim_s[QB];
	assign q_re       = qre_s[QB];
	assign q_im       = qim_s[QB];
	assign ovf_re     = ovre_s[QB];
	assign ovf_im     = ovim_s[QB];
	assign out_dzero  = dz_s[QB];

endmodule

[src/cau_pack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit output stage
// Picks the magnitude for the operation, saturates each part, builds the
// status and holds the result in the output register.
// ----------------------------------------------------------------------------
module cau_pack #(
	parameter int DW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cau_pkg::cmd_t        cmd,
	input  logic                 neg_re,
	input  logic [2*DW-1:0]      mag_re,
	input  logic                 neg_im,
	input  logic [2*DW-1:0]      mag_im,
	input  logic [DW:0]          q_re,
	input  logic [DW:0]          q_im,
	input  logic                 ovf_re,
	input  logic                 ovf_im,
	input  logic                 dzero,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [DW-1:0] r_re,
	output logic signed [DW-1:0] r_im,
	output logic [1:0]           status
);

	localparam int MW = 2 * DW;
	localparam logic [MW-1:0] PMAX = {{(MW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [MW-1:0] NMAX = PMAX + MW'(1);

	logic          vld_q, en;
	logic [MW-1:0] mre, mim;
	logic [DW:0]   pre, pim;
	logic          div;

	// Saturate a sign and magnitude pair; the top bit flags saturation.
	function automatic logic [DW:0] sat_part(input logic neg, input logic [MW-1:0] m);
		logic          s;
		logic [MW-1:0] mm;
		logic [MW-1:0] v;
		s  = neg ? (m > NMAX) : (m > PMAX);
		mm = s ? (neg ? NMAX : PMAX) : m;
		v  = neg ? (MW'(0) - mm) : mm;
		return {s, v[DW-1:0]};
	endfunction

	// Quotient for divides, with overflow forced to the top.
	always_comb begin
		div = (cmd == cau_pkg::CMD_DIV);
		mre = div ? (ovf_re ? '1 : MW'(q_re)) : mag_re;
		mim = div ? (ovf_im ? '1 : MW'(q_im)) : mag_im;
		pre = sat_part(neg_re, mre);
		pim = sat_part(neg_im, mim);
	end

	assign en        = !vld_q || !out_stall;
	assign in_stall  = !en;
	assign out_valid = vld_q;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			if (div && dzero) begin
				r_re   <= '0;
				r_im   <= '0;
				status <= cau_pkg::ST_DIVZ;
			end else begin
				r_re   <= pre[DW-1:0];
				r_im   <= pim[DW-1:0];
				status <= (pre[DW] || pim[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end
		end
	end

endmodule

[src/complex_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit core
// Add, multiply, divide and conjugate of signed fixed point complex numbers.
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_stall  | cmd, x_re, x_im, y_re, y_im
//   output  | out       | out_valid / out_stall| r_re, r_im, status
//
// One item per cycle enters while in_stall is low, and the divider
// resolves one quotient bit per stage.
// Reset clears only the stage valid bits; the pipeline is empty after reset.
// A stall holds only the stages that are full; empty stages keep filling.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   cmd,
	input  logic signed [DATA_WIDTH-1:0] x_re,
	input  logic signed [DATA_WIDTH-1:0] x_im,
	input  logic signed [DATA_WIDTH-1:0] y_re,
	input  logic signed [DATA_WIDTH-1:0] y_im,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] r_re,
	output logic signed [DATA_WIDTH-1:0] r_im,
	output logic [1:0]                   status
);

	localparam int MW = 2 * DATA_WIDTH;

	logic          f_valid, f_stall;
	cau_pkg::cmd_t f_cmd;
	logic          f_nre, f_nim, f_dz;
	logic [MW-1:0] f_mre, f_mim, f_den;

	logic                  d_valid, d_stall;
	cau_pkg::cmd_t         d_cmd;
	logic                  d_nre, d_nim, d_ore, d_oim, d_dz;
	logic [MW-1:0]         d_mre, d_mim;
	logic [DATA_WIDTH:0]   d_qre, d_qim;

	// Products, sums and divisor norm.
	cau_front #(.DW(DATA_WIDTH), .F(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cau_pkg::cmd_t'(cmd)),
		.x_re(x_re), .x_im(x_im), .y_re(y_re), .y_im(y_im),
		.out_valid(f_valid), .out_stall(f_stall),
		.out_cmd(f_cmd), .neg_re(f_nre), .mag_re(f_mre),
		.neg_im(f_nim), .mag_im(f_mim), .den(f_den), .dzero(f_dz)
	);

	// Bit-per-stage divider.
	cau_div #(.DW(DATA_WIDTH), .F(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_stall(f_stall),
		.cmd(f_cmd), .neg_re(f_nre), .mag_re(f_mre),
		.neg_im(f_nim), .mag_im(f_mim), .den(f_den), .dzero(f_dz),
		.out_valid(d_valid), .out_stall(d_stall),
		.out_cmd(d_cmd), .out_neg_re(d_nre), .out_mag_re(d_mre),
		.out_neg_im(d_nim), .out_mag_im(d_mim),
		.q_re(d_qre), .q_im(d_qim), .ovf_re(d_ore), .ovf_im(d_oim),
		.out_dzero(d_dz)
	);

	// Saturation, status and output register.
	cau_pack #(.DW(DATA_WIDTH)) u_pack (
		.clk(clk), .arst_n(arst_n),
		.in_valid(d_valid), .in_stall(d_stall),
		.cmd(d_cmd), .neg_re(d_nre), .mag_re(d_mre),
		.neg_im(d_nim), .mag_im(d_mim),
		.q_re(d_qre), .q_im(d_qim), .ovf_re(d_ore), .ovf_im(d_oim),
		.dzero(d_dz),
		.out_valid(out_valid), .out_stall(out_stall),
		.r_re(r_re), .r_im(r_im), .status(status)
	);

endmodule

[src/cau_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level checks on the output channel and the backpressure path.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cau_checker #(
	parameter int DATA_WIDTH = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [DATA_WIDTH-1:0] r_re,
	input logic [DATA_WIDTH-1:0] r_im,
	input logic [1:0]            status
);

	// A stalled result stays offered.
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

	// A stalled result keeps its value.
	`CHK_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(r_re) && $stable(r_im) && $stable(status), "stalled result changed")

	// With the output free, the pipeline always takes a new item.
	`CHK_ALWAYS(a_no_stall, clk, arst_n, !out_stall |-> !in_stall, "input stalled with output free")

	// A zero divisor result is zero in both parts.
	`CHK_ALWAYS(a_divz_zero, clk, arst_n, (out_valid && status == cau_pkg::ST_DIVZ) |-> (r_re == '0 && r_im == '0), "nonzero result on zero divisor")

endmodule

bind complex_arithmetic_unit_core cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.r_re(r_re), .r_im(r_im), .status(status)
);

[tb/tb_complex_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit core testbench
// Drives add, multiply, divide and conjugate operations through the valid and
// stall handshake with random gaps on both sides. A scoreboard predicts each
// result with saturation and status in fixed point and checks the outputs in
// order.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit_core;

	localparam int DW = 16;
	localparam int FB = 8;
	localparam int LATENCY = DW + 5;
	localparam int NUM_RANDOM = 1350;
	localparam longint CYCLE_LIMIT = 400000;

	// One predicted result.
	typedef struct {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		cau_pkg::status_t st;
	} cplx_result_t;

	// Fixed point predictor and the queue of results still to come.
	class cplx_scoreboard;
		cplx_result_t pending[$];
		int errors;
		int n_checked;

		function void clamp(input longint v, output logic [DW-1:0] r, inout bit sat);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (DW - 1)) - 1;
			lo = -(longint'(1) <<< (DW - 1));
			if (v > hi) begin
				sat = 1;
				r = hi[DW-1:0];
			end else if (v < lo) begin
				sat = 1;
				r = lo[DW-1:0];
			end else begin
				r = v[DW-1:0];
			end
		endfunction

		// Restoring division of a magnitude, with the integer part capped.
		function longint frac_div(input longint num, input longint den);
			longint q;
			longint r;
			q = num / den;
			r = num % den;
			if (q > (longint'(1) <<< DW))
				q = longint'(1) <<< DW;
			for (int i = 0; i < FB; i++) begin
				r = r <<< 1;
				q = q <<< 1;
				if (r >= den) begin
					r = r - den;
					q = q | 1;
				end
			end
			return q;
		endfunction

		// Magnitudes stay far below 2^62, so plain signed math is exact.
		function void note_input(input cau_pkg::cmd_t op, input logic signed [DW-1:0] xr,
				input logic signed [DW-1:0] xi, input logic signed [DW-1:0] yr,
				input logic signed [DW-1:0] yi);
			longint a;
			longint b;
			longint den;
			longint ma;
			longint mb;
			bit sat;
			cplx_result_t res;
			sat = 0;
			res.st = cau_pkg::ST_OK;
			den = longint'(yr) * yr + longint'(yi) * yi;
			case (op)
				cau_pkg::CMD_ADD: begin
					a = longint'(xr) + yr;
					b = longint'(xi) + yi;
				end
				cau_pkg::CMD_MUL: begin
					a = longint'(xr) * yr - longint'(xi) * yi;
					b = longint'(xr) * yi + longint'(xi) * yr;
				end
				cau_pkg::CMD_DIV: begin
					a = longint'(xr) * yr + longint'(xi) * yi;
					b = longint'(xi) * yr - longint'(xr) * yi;
				end
				default: begin
					a = xr;
					b = -longint'(xi);
				end
			endcase
			ma = (a < 0) ? -a : a;
			mb = (b < 0) ? -b : b;
			if (op == cau_pkg::CMD_MUL) begin
				ma = ma >>> FB;
				mb = mb >>> FB;
			end else if (op == cau_pkg::CMD_DIV && den != 0) begin
				ma = frac_div(ma, den);
				mb = frac_div(mb, den);
			end
			if (op == cau_pkg::CMD_DIV && den == 0) begin
				res.re = '0;
				res.im = '0;
				res.st = cau_pkg::ST_DIVZ;
			end else begin
				clamp((a < 0) ? -ma : ma, res.re, sat);
				clamp((b < 0) ? -mb : mb, res.im, sat);
				if (sat)
					res.st = cau_pkg::ST_SAT;
			end
			pending.push_back(res);
		endfunction

		function void check_result(input logic [DW-1:0] re, input logic [DW-1:0] im,
				input logic [1:0] st);
			cplx_result_t e;
			n_checked++;
			if (pending.size() == 0) begin
				$error("result with no transfer pending: re=%h im=%h status=%0d", re, im, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (re !== e.re) begin
				$error("r_re expected %h actual %h", e.re, re);
				errors++;
			end
			if (im !== e.im) begin
				$error("r_im expected %h actual %h", e.im, im);
				errors++;
			end
			if (st !== e.st) begin
				$error("status expected %0d actual %0d", e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] cmd;
	logic signed [DW-1:0] x_re;
	logic signed [DW-1:0] x_im;
	logic signed [DW-1:0] y_re;
	logic signed [DW-1:0] y_im;
	logic out_valid;
	logic out_stall;
	logic signed [DW-1:0] r_re;
	logic signed [DW-1:0] r_im;
	logic [1:0] status;

	cplx_scoreboard sb;
	longint cycle_count;
	bit sender_done;
	bit hold_output;
	int n_sent;

	complex_arithmetic_unit_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .x_re(x_re), .x_im(x_im), .y_re(y_re), .y_im(y_im),
		.out_valid(out_valid), .out_stall(out_stall), .r_re(r_re), .r_im(r_im),
		.status(status)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Send one item, after a random gap when gaps is set, and wait for its transfer.
	// Valid stays high after a transfer so that items can follow back to back.
	task automatic send_item(input cau_pkg::cmd_t op, input logic [DW-1:0] xr,
			input logic [DW-1:0] xi, input logic [DW-1:0] yr, input logic [DW-1:0] yi,
			input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 16) : 0;
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		x_re <= xr;
		x_im <= xi;
		y_re <= yr;
		y_im <= yi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(op, xr, xi, yr, yi);
		n_sent++;
	endtask

	// Operand values biased toward the edges of the range.
	function automatic logic [DW-1:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return DW'($urandom_range(0, 15) - 8);
			3: return DW'($urandom_range(0, 4095) - 2048);
			default: return DW'($urandom());
		endcase
	endfunction

	// Stimulus.
	initial begin
		logic [DW-1:0] ext[4];
		cau_pkg::cmd_t op;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = cau_pkg::CMD_ADD;
		x_re = '0;
		x_im = '0;
		y_re = '0;
		y_im = '0;
		sender_done = 0;
		hold_output = 0;
		n_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: extremes, zero divisor and conjugate saturation.
		ext = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
		for (int o = 0; o < 4; o++)
			for (int k = 0; k < 4; k++)
				send_item(cau_pkg::cmd_t'(o), ext[k], ext[(k + 1) % 4], ext[(k + 2) % 4],
					ext[(k + 3) % 4], 0);
		send_item(cau_pkg::CMD_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 0);
		send_item(cau_pkg::CMD_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h7fff, 0);
		send_item(cau_pkg::CMD_DIV, 16'hffff, 16'h0000, 16'h0200, 16'h0000, 0);
		send_item(cau_pkg::CMD_CONJ, 16'h1234, 16'h8000, 16'h0000, 16'h0000, 0);
		send_item(cau_pkg::CMD_MUL, 16'hff80, 16'h0000, 16'h0001, 16'h0000, 0);
		send_item(cau_pkg::CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);

		// Sender pauses until every expected result has come.
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);

		// Receiver holds off for a long stretch while items keep coming.
		hold_output = 1;
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == 60)
				hold_output = 0;
			op = cau_pkg::cmd_t'($urandom_range(0, 3));
			send_item(op, pick_operand(), pick_operand(),
				($urandom_range(0, 19) == 0) ? '0 : pick_operand(),
				($urandom_range(0, 19) == 0) ? '0 : pick_operand(), i >= 60);
		end
		in_valid <= 1'b0;
		sender_done = 1;
	end

	// Receiver stall: random holds per result, plus one long hold-off.
	initial begin
		int gap;
		bit long_done;
		out_stall = 1'b1;
		long_done = 0;
		@(posedge arst_n);
		forever begin
			if (hold_output && !long_done) begin
				out_stall <= 1'b1;
				repeat (200) @(posedge clk);
				long_done = 1;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Output monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(r_re, r_im, status);
	end

	// Cycle limit and end of run.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("CHECK FAILED");
				$finish;
			end
			if (sender_done && sb.pending.size() == 0) begin
				repeat (LATENCY * 4) @(posedge clk);
				$display("Sent %0d items over all four operations, %0d results checked.",
					n_sent, sb.n_checked);
				$display("Covered edge operands, zero divisors, saturation and long stalls.");
				if (sb.errors == 0 && sb.pending.size() == 0)
					$display("CHECK OK");
				else
					$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule
